// ----- rtl/arbt_pkg.sv -----
// shared types and codes for the address range buffer table
`timescale 1ns / 1ps
package arbt_pkg;

  // request commands
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POINT  = 2'd2,
    CMD_RANGE  = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_t        cmd;
    logic [63:0] addr;
    logic [63:0] host;
    logic [63:0] len;
    logic [15:0] id;
    logic [63:0] span_lim;
    logic        invalid;
  } req_t;

  // one table entry as stored in memory
  typedef struct packed {
    logic [63:0] dbase;
    logic [63:0] hbase;
    logic [63:0] elen;
    logic [15:0] tag;
  } entry_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD,
    BK_CK,
    BK_SH_RD,
    BK_SH_WR
  } bk_state_t;

endpackage

// ----- rtl/arbt_ram.sv -----
// generic single write, single read memory with registered read
`timescale 1ns / 1ps
module arbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/arbt_front.sv -----
// front end: accepts requests, classifies them, holds them in a one-slot queue
`timescale 1ns / 1ps
module arbt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_cmd,
  input  logic [63:0]         in_addr,
  input  logic [63:0]         in_host_addr,
  input  logic [63:0]         in_length,
  input  logic [15:0]         in_buffer_id,
  output logic                q_valid,
  output arbt_pkg::req_t      q_req,
  input  logic                q_pop
);
  import arbt_pkg::*;

  logic        q_valid_r;
  logic        q_valid_nxt;
  req_t        q_req_r;
  req_t        req_in;
  logic        accept;
  logic [63:0] span_lim;

  assign accept = start && !q_valid_r;
  assign busy   = q_valid_r;

  // classify: range end and argument check for range lookup
  always_comb begin
    span_lim         = in_addr + in_length;
    req_in.cmd       = cmd_t'(in_cmd);
    req_in.addr      = in_addr;
    req_in.host      = in_host_addr;
    req_in.len       = in_length;
    req_in.id        = in_buffer_id;
    req_in.span_lim  = span_lim;
    req_in.invalid   = (cmd_t'(in_cmd) == CMD_RANGE) &&
                       ((in_length == 64'd0) || (span_lim < in_addr));
  end

  // queue occupancy
  always_comb begin
    q_valid_nxt = q_valid_r;
    if (q_pop) begin
      q_valid_nxt = 1'b0;
    end
    if (accept) begin
      q_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
    end else begin
      q_valid_r <= q_valid_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      q_req_r <= req_in;
    end
  end

  assign q_valid = q_valid_r;
  assign q_req   = q_req_r;

endmodule

// ----- rtl/arbt_back.sv -----
// back end: scans the entry memory, inserts, removes with compaction, answers
`timescale 1ns / 1ps
module arbt_back #(
  parameter int ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  arbt_pkg::req_t q_req,
  output logic           q_pop,
  output logic           out_valid,
  output logic [2:0]     out_status,
  output logic [15:0]    out_match_id
);
  import arbt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [CW-1:0] ONE      = CW'(1);

  bk_state_t     state_r, state_nxt;
  req_t          req_r, req_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          phase_r, phase_nxt;
  logic          ov_r, ov_nxt;
  status_t       st_r, st_nxt;
  logic [15:0]   mid_r, mid_nxt;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  entry_t        ent, new_ent;
  logic [63:0]   key, dev_end, hbase_lim;
  logic          hit_pt, hit_rg, hit;
  logic [CW-1:0] idx_inc;

  arbt_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // containment check against the entry read last cycle
  always_comb begin
    ent       = entry_t'(rdata);
    key       = phase_r ? req_r.host : req_r.addr;
    dev_end   = ent.dbase + ent.elen;
    hbase_lim = ent.hbase + ent.elen;
    hit_pt    = (key >= ent.dbase && key < dev_end) ||
                (ent.hbase != 64'd0 && key >= ent.hbase && key < hbase_lim);
    hit_rg    = (req_r.addr >= ent.dbase && req_r.span_lim <= dev_end) ||
                (ent.hbase != 64'd0 && req_r.addr >= ent.hbase &&
                 req_r.span_lim <= hbase_lim);
    hit       = (req_r.cmd == CMD_RANGE) ? hit_rg : hit_pt;
    idx_inc   = idx_r + ONE;
    new_ent.dbase = req_r.addr;
    new_ent.hbase = req_r.host;
    new_ent.elen  = req_r.len;
    new_ent.tag   = req_r.id;
  end

  // sequencer next state and outputs
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    ov_nxt    = 1'b0;
    st_nxt    = st_r;
    mid_nxt   = mid_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = idx_r[IW-1:0];
    wdata     = rdata;
    raddr     = idx_r[IW-1:0];
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          req_nxt   = q_req;
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          if (q_req.invalid) begin
            ov_nxt  = 1'b1;
            st_nxt  = ST_INVALID;
            mid_nxt = 16'd0;
          end else begin
            state_nxt = BK_RD;
          end
        end
      end
      BK_RD: begin
        if (idx_r >= count_r) begin
          // no entry matched this pass
          mid_nxt = 16'd0;
          if (req_r.cmd == CMD_INSERT) begin
            if (!phase_r && req_r.host != 64'd0) begin
              phase_nxt = 1'b1;
              idx_nxt   = '0;
            end else if (count_r >= FULL_CNT) begin
              ov_nxt    = 1'b1;
              st_nxt    = ST_FULL;
              state_nxt = BK_IDLE;
            end else begin
              we        = 1'b1;
              waddr     = count_r[IW-1:0];
              wdata     = EW'(new_ent);
              count_nxt = count_r + ONE;
              ov_nxt    = 1'b1;
              st_nxt    = ST_OK;
              state_nxt = BK_IDLE;
            end
          end else begin
            ov_nxt    = 1'b1;
            st_nxt    = ST_NOT_FOUND;
            state_nxt = BK_IDLE;
          end
        end else begin
          state_nxt = BK_CK;
        end
      end
      BK_CK: begin
        if (hit) begin
          mid_nxt = 16'd0;
          unique case (req_r.cmd)
            CMD_INSERT: begin
              ov_nxt    = 1'b1;
              st_nxt    = ST_EXISTS;
              state_nxt = BK_IDLE;
            end
            CMD_REMOVE: begin
              state_nxt = BK_SH_RD;
            end
            CMD_POINT, CMD_RANGE: begin
              ov_nxt    = 1'b1;
              st_nxt    = ST_OK;
              mid_nxt   = ent.tag;
              state_nxt = BK_IDLE;
            end
            default: state_nxt = BK_IDLE;
          endcase
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = BK_RD;
        end
      end
      BK_SH_RD: begin
        // move the next entry down one slot
        raddr = idx_inc[IW-1:0];
        if (idx_inc < count_r) begin
          state_nxt = BK_SH_WR;
        end else begin
          count_nxt = count_r - ONE;
          ov_nxt    = 1'b1;
          st_nxt    = ST_OK;
          mid_nxt   = 16'd0;
          state_nxt = BK_IDLE;
        end
      end
      BK_SH_WR: begin
        we        = 1'b1;
        waddr     = idx_r[IW-1:0];
        wdata     = rdata;
        idx_nxt   = idx_inc;
        state_nxt = BK_SH_RD;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    phase_r <= phase_nxt;
    st_r    <= st_nxt;
    mid_r   <= mid_nxt;
  end

  assign out_valid    = ov_r;
  assign out_status   = st_r;
  assign out_match_id = mid_r;

endmodule

// ----- rtl/address_range_buffer_table.sv -----
// top level of the address range buffer table
//
// Ordered table of up to ENTRIES buffers (device base, host base, length, id).
// Requests enter on start/in_* when busy is low: insert, remove, point lookup
// or range lookup. Every request gives exactly one result, shown for one
// cycle with out_valid high, with out_status and out_match_id.
// The front end classifies a request and holds it in a one-slot queue, so a
// second request is taken while the back end still works on the first.
// The back end reads the entry memory through its single read port, visiting
// each entry with an address step (BK_RD) and then a compare step (BK_CK). An
// insert with a nonzero host base scans the table once more for the host base,
// a remove moves every entry behind the removed one down one slot, and a range
// lookup with bad arguments is answered without a scan of the table.
// Results leave in request order. The receiver cannot stall, out_valid is a
// one cycle strobe. Reset empties the table (entry count to zero); no memory
// clearing pass is needed, so requests are taken right after reset.
`timescale 1ns / 1ps
module address_range_buffer_table #(
  parameter int ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_addr,
  input  logic [63:0] in_host_addr,
  input  logic [63:0] in_length,
  input  logic [15:0] in_buffer_id,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_match_id
);
  import arbt_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_req;

  // request intake and queue
  arbt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_cmd      (in_cmd),
    .in_addr     (in_addr),
    .in_host_addr(in_host_addr),
    .in_length   (in_length),
    .in_buffer_id(in_buffer_id),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop)
  );

  // table sequencer
  arbt_back #(.ENTRIES(ENTRIES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_match_id(out_match_id)
  );

endmodule

// ----- rtl/arbt_checker.sv -----
// port level checker for the address range buffer table, with its bind
`timescale 1ns / 1ps
module arbt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [2:0]  out_status,
  input logic [15:0] out_match_id
);
  import arbt_pkg::*;

  // status is always a known code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_EXISTS ||
                   out_status == ST_NOT_FOUND || out_status == ST_INVALID ||
                   out_status == ST_FULL))
    else $error("unknown status code");

  // failed requests carry no id
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_match_id == 16'd0))
    else $error("failed request returned an id");

  // an accepted request fills the queue
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("queue not marked full after request");

  // no result in the first cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind address_range_buffer_table arbt_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_status  (out_status),
  .out_match_id(out_match_id)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the address range buffer table
`timescale 1ns / 1ps
module testbench;
  import arbt_pkg::*;

  localparam int DEPTH = 64;

  // region table predictor and queue of pending results
  class region_scoreboard;
    logic [63:0] dev_q[$];
    logic [63:0] host_q[$];
    logic [63:0] len_q[$];
    logic [15:0] tag_q[$];
    logic [2:0]  want_status[$];
    logic [15:0] want_id[$];
    int          errors;

    function bit hits(logic [63:0] a, logic [63:0] b, logic [63:0] n);
      logic [63:0] e;
      e = b + n;
      return (a >= b) && (a < e);
    endfunction

    // first entry holding the address, or -1
    function int find_point(logic [63:0] a);
      for (int i = 0; i < dev_q.size(); i++) begin
        if (hits(a, dev_q[i], len_q[i])) return i;
        if (host_q[i] != 0 && hits(a, host_q[i], len_q[i])) return i;
      end
      return -1;
    endfunction

    function int find_range(logic [63:0] a, logic [63:0] e);
      logic [63:0] lim;
      for (int i = 0; i < dev_q.size(); i++) begin
        lim = dev_q[i] + len_q[i];
        if (a >= dev_q[i] && e <= lim) return i;
        lim = host_q[i] + len_q[i];
        if (host_q[i] != 0 && a >= host_q[i] && e <= lim) return i;
      end
      return -1;
    endfunction

    function int count();
      return dev_q.size();
    endfunction

    // note an accepted request and queue its result
    function void note_request(cmd_t c, logic [63:0] a, logic [63:0] h,
                               logic [63:0] n, logic [15:0] id);
      status_t st;
      logic [15:0] m;
      logic [63:0] e;
      int idx;
      st = ST_OK;
      m = '0;
      case (c)
        CMD_INSERT: begin
          if (find_point(a) >= 0) st = ST_EXISTS;
          else if (h != 0 && find_point(h) >= 0) st = ST_EXISTS;
          else if (dev_q.size() >= DEPTH) st = ST_FULL;
          else begin
            dev_q.push_back(a); host_q.push_back(h);
            len_q.push_back(n); tag_q.push_back(id);
          end
        end
        CMD_REMOVE: begin
          idx = find_point(a);
          if (idx < 0) st = ST_NOT_FOUND;
          else begin
            dev_q.delete(idx); host_q.delete(idx);
            len_q.delete(idx); tag_q.delete(idx);
          end
        end
        CMD_POINT: begin
          idx = find_point(a);
          if (idx < 0) st = ST_NOT_FOUND;
          else m = tag_q[idx];
        end
        default: begin
          e = a + n;
          if (n == 0 || e < a) st = ST_INVALID;
          else begin
            idx = find_range(a, e);
            if (idx < 0) st = ST_NOT_FOUND;
            else m = tag_q[idx];
          end
        end
      endcase
      want_status.push_back(st);
      want_id.push_back(m);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one result with the oldest expectation
    task check_result(logic [2:0] st, logic [15:0] id);
      logic [2:0] ws;
      logic [15:0] wi;
      if (want_status.size() == 0) begin
        report($sformatf("unexpected result status %0d id %0h", st, id));
      end else begin
        ws = want_status.pop_front();
        wi = want_id.pop_front();
        if (st !== ws) report($sformatf("status %0d, want %0d", st, ws));
        if (id !== wi) report($sformatf("match_id %0h, want %0h", id, wi));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [63:0] in_addr;
  logic [63:0] in_host_addr;
  logic [63:0] in_length;
  logic [15:0] in_buffer_id;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_match_id;

  region_scoreboard sb;
  bit quiet_phase;
  int sent;

  address_range_buffer_table #(.ENTRIES(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_addr(in_addr), .in_host_addr(in_host_addr),
    .in_length(in_length), .in_buffer_id(in_buffer_id),
    .out_valid(out_valid), .out_status(out_status), .out_match_id(out_match_id)
  );

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_match_id);
  end

  // drive one request, with random idle cycles ahead of it
  task send_request(cmd_t c, logic [63:0] a, logic [63:0] h, logic [63:0] n,
                    logic [15:0] id);
    while (!quiet_phase && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_cmd       <= c;
    in_addr      <= a;
    in_host_addr <= h;
    in_length    <= n;
    in_buffer_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(c, a, h, n, id);
    sent++;
  endtask

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // addresses from a small window so that hits are common
  function logic [63:0] near_addr();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = rand64();
      1: v = 64'hFFFF_FFFF_FFFF_FF00 + $urandom_range(255);
      2: v = $urandom_range(255);
      default: v = 64'h1000 + $urandom_range(16'hFFFF);
    endcase
    return v;
  endfunction

  function logic [63:0] rand_len();
    logic [63:0] v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = rand64();
      2: v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(3);
      default: v = $urandom_range(1, 600);
    endcase
    return v;
  endfunction

  // random request mix biased by table fill
  task random_request();
    cmd_t c;
    int pick;
    logic [63:0] h;
    pick = $urandom_range(99);
    if (sb.count() < 20) c = (pick < 45) ? CMD_INSERT : (pick < 60) ? CMD_REMOVE :
                             (pick < 80) ? CMD_POINT : CMD_RANGE;
    else c = (pick < 25) ? CMD_INSERT : (pick < 50) ? CMD_REMOVE :
             (pick < 75) ? CMD_POINT : CMD_RANGE;
    h = ($urandom_range(2) == 0) ? 64'h0 : near_addr();
    send_request(c, near_addr(), h, rand_len(), 16'($urandom()));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_INSERT;
    in_addr = '0;
    in_host_addr = '0;
    in_length = '0;
    in_buffer_id = '0;
    quiet_phase = 1'b0;
    sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, wraps, overlaps, zero length
    send_request(CMD_POINT, 64'h0, 64'h0, 64'h0, 16'h0);
    send_request(CMD_REMOVE, '1, 64'h0, 64'h0, 16'h0);
    send_request(CMD_INSERT, 64'h100, 64'h0, 64'h100, 16'hFFFF);
    send_request(CMD_INSERT, 64'h1FF, 64'h0, 64'h10, 16'h1);
    send_request(CMD_INSERT, 64'h200, 64'h180, 64'h10, 16'h2);
    send_request(CMD_INSERT, 64'h300, '1, 64'h0, 16'h3);
    send_request(CMD_POINT, 64'h300, 64'h0, 64'h0, 16'h0);
    send_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h0, 64'h20, 16'h4);
    send_request(CMD_POINT, 64'hFFFF_FFFF_FFFF_FFF8, 64'h0, 64'h0, 16'h0);
    send_request(CMD_INSERT, 64'h400, 64'h8000, 64'h40, 16'h5);
    send_request(CMD_POINT, 64'h8010, 64'h0, 64'h0, 16'h0);
    send_request(CMD_RANGE, 64'h100, 64'h0, 64'h100, 16'h0);
    send_request(CMD_RANGE, 64'h100, 64'h0, 64'h101, 16'h0);
    send_request(CMD_RANGE, 64'h8000, 64'h0, 64'h40, 16'h0);
    send_request(CMD_RANGE, 64'h100, 64'h0, 64'h0, 16'h0);
    send_request(CMD_RANGE, '1, '1, '1, '1);
    send_request(CMD_REMOVE, 64'h150, 64'h0, 64'h0, 16'h0);
    send_request(CMD_POINT, 64'h8000, 64'h0, 64'h0, 16'h0);
    send_request(CMD_INSERT, 64'h10_0000, 64'h8020, 64'h8, 16'h6);

    // fill to capacity and beyond
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(CMD_INSERT, 64'h100_0000 + 64'(i) * 64'h100, 64'h0, 64'h10,
                   16'($urandom()));
    // drain with removes
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(CMD_REMOVE, (i < 8) ? near_addr() : 64'h100_0000 +
                   64'(DEPTH + 1 - i) * 64'h100, 64'h0, 64'h0, 16'h0);

    // random part, with one stretch without idling
    for (int i = 0; i < 1000; i++) begin
      quiet_phase = (i >= 400 && i < 550);
      random_request();
    end
    start <= 1'b0;

    // wait for outstanding results
    fork
      begin
        while (sb.want_status.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
      end
      begin
        repeat (200000) @(posedge clk);
      end
    join_any
    disable fork;
    if (sb.errors == 0 && sb.want_status.size() == 0)
      $display("** address_range_buffer_table: PASSED **");
    else
      $display("** address_range_buffer_table: FAILED **");
    $finish;
  end

  // overall time limit
  initial begin
    #50ms;
    $display("** address_range_buffer_table: FAILED **");
    $finish;
  end
endmodule

// ----- address_range_buffer_table.f -----
rtl/arbt_pkg.sv
rtl/arbt_ram.sv
rtl/arbt_front.sv
rtl/arbt_back.sv
rtl/address_range_buffer_table.sv
rtl/arbt_checker.sv
tb/testbench.sv
